// ===== hdl/rmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rmcs_pkg
// Shared types and constants of the movi chunk scanner.
// ----------------------------------------------------------------------------
package rmcs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_REGION_BASE   = 2'd0;
  localparam logic [1:0] REG_REGION_LENGTH = 2'd1;
  localparam logic [1:0] REG_VIDEO_STREAM  = 2'd2;
  localparam logic [1:0] REG_AUDIO_STREAM  = 2'd3;

  localparam logic [6:0] AUDIO_STREAM_RESET = 7'd127;

  // Chunk header layout and tag constants.
  localparam logic [31:0] TAG_LIST        = 32'h5453_494C;
  localparam logic [15:0] TYPE_DC         = 16'h6364;
  localparam logic [15:0] TYPE_DB         = 16'h6264;
  localparam logic [15:0] TYPE_WB         = 16'h6277;
  localparam logic [7:0]  CHAR_0          = 8'h30;
  localparam logic [7:0]  CHAR_9          = 8'h39;
  localparam logic [31:0] LIST_TYPE_BYTES = 32'd4;
  localparam logic [33:0] HEADER_BYTES    = 34'd8;

  // Depth of the header queue between the front and back ends.
  localparam int FIFO_DEPTH = 4;

  // One collected chunk header, handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] size;
    logic [31:0] pos;   // region offset of the payload (header position + 8)
  } hdr_rec_t;

endpackage

// ===== hdl/rmcs_fifo.sv =====
// ----------------------------------------------------------------------------
// rmcs_fifo
// Short queue of collected chunk headers between the front and back ends.
// ----------------------------------------------------------------------------
module rmcs_fifo
  import rmcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hdr_rec_t push_rec,
  input  logic     pop,
  output hdr_rec_t head_rec,
  output logic     empty,
  output logic     full
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  hdr_rec_t            entries [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign empty    = (count == '0);
  assign full     = (count == CntW'(FIFO_DEPTH));
  assign head_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PtrW'((CntW'(wr_ptr) + CntW'(1)) % CntW'(FIFO_DEPTH));
      end
      if (pop) begin
        rd_ptr <= PtrW'((CntW'(rd_ptr) + CntW'(1)) % CntW'(FIFO_DEPTH));
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // The front end is held off while full, and the back end only drains a
  // non-empty queue.
  a_no_overflow_underflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("header queue overflow or underflow");

endmodule

// ===== hdl/rmcs_front.sv =====
// ----------------------------------------------------------------------------
// rmcs_front
// Byte-level walk of the movi region: collects chunk headers and skips
// payloads and list types.
// ----------------------------------------------------------------------------
module rmcs_front
  import rmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_fire,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic [31:0] region_length,
  output logic        push,
  output hdr_rec_t    push_rec
);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SKIP,
    ST_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] header_bytes, header_bytes_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [32:0] region_position, region_position_next;

  phase_t      ph_cur;
  logic [2:0]  cnt_cur;
  logic [31:0] skip_cur;
  logic [32:0] pos_cur;
  logic [63:0] hdr_shift;
  logic [31:0] size_p1;
  logic [31:0] pad_skip;

  always_comb begin
    // A restart byte sees the reset state.
    ph_cur   = restart ? ST_COLLECT : phase;
    cnt_cur  = restart ? 3'd0 : header_count;
    skip_cur = restart ? 32'd0 : skip_remaining;
    pos_cur  = restart ? 33'd0 : region_position;

    hdr_shift = {data_byte, header_bytes[63:8]};
    size_p1   = hdr_shift[63:32] + 32'd1;
    pad_skip  = {size_p1[31:1], 1'b0};

    phase_next           = ph_cur;
    header_bytes_next    = header_bytes;
    header_count_next    = cnt_cur;
    skip_remaining_next  = skip_cur;
    region_position_next = pos_cur;
    push                 = 1'b0;
    push_rec.tag         = hdr_shift[31:0];
    push_rec.size        = hdr_shift[63:32];
    push_rec.pos         = region_position_next[31:0];

    unique case (ph_cur)
      ST_SKIP: begin
        if (skip_cur != 32'd0) begin
          skip_remaining_next = skip_cur - 32'd1;
        end
        region_position_next = pos_cur + 33'd1;
        if (skip_remaining_next == 32'd0) begin
          phase_next = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (cnt_cur == 3'd0 && ({1'b0, pos_cur} + HEADER_BYTES) > {2'b00, region_length}) begin
          phase_next = ST_DONE;
        end else begin
          header_bytes_next    = hdr_shift;
          header_count_next    = cnt_cur + 3'd1;
          region_position_next = pos_cur + 33'd1;
          if (cnt_cur == 3'd7) begin
            if (hdr_shift[31:0] == TAG_LIST) begin
              skip_remaining_next = LIST_TYPE_BYTES;
              phase_next          = ST_SKIP;
            end else begin
              skip_remaining_next = pad_skip;
              phase_next          = (pad_skip == 32'd0) ? ST_COLLECT : ST_SKIP;
              push                = byte_fire;
            end
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
        phase_next = ST_DONE;
      end
    endcase
    push_rec.pos = region_position_next[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ST_COLLECT;
      header_bytes    <= '0;
      header_count    <= '0;
      skip_remaining  <= '0;
      region_position <= '0;
    end else if (byte_fire) begin
      phase           <= phase_next;
      header_bytes    <= header_bytes_next;
      header_count    <= header_count_next;
      skip_remaining  <= skip_remaining_next;
      region_position <= region_position_next;
    end
  end

  // The skip phase always has bytes left to skip; it is left on the last one.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == ST_SKIP) |-> (skip_remaining != 32'd0))
    else $error("skip phase with nothing left to skip");

endmodule

// ===== hdl/rmcs_back.sv =====
// ----------------------------------------------------------------------------
// rmcs_back
// Classifies queued chunk headers and presents the descriptors.
// ----------------------------------------------------------------------------
module rmcs_back
  import rmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  hdr_rec_t    head_rec,
  input  logic        empty,
  output logic        pop,
  input  logic [31:0] region_base,
  input  logic [6:0]  video_stream,
  input  logic [6:0]  audio_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] chunk_offset,
  output logic [31:0] chunk_length,
  output logic        is_audio,
  output logic        key_frame,
  output logic [6:0]  stream_number
);

  logic [7:0]  s0, s1, d0_full, d1_full;
  logic [15:0] chunk_type;
  logic        digits_ok;
  logic [6:0]  num;
  logic        video, audio, hit;
  logic        out_free;

  always_comb begin
    s0         = head_rec.tag[7:0];
    s1         = head_rec.tag[15:8];
    chunk_type = head_rec.tag[31:16];
    digits_ok  = (s0 >= CHAR_0) && (s0 <= CHAR_9) && (s1 >= CHAR_0) && (s1 <= CHAR_9);
    d0_full    = s0 - CHAR_0;
    d1_full    = s1 - CHAR_0;
    // Tens digit times ten as two shifts; the sum stays below 100.
    num        = {d0_full[3:0], 3'b000} + {2'b00, d0_full[3:0], 1'b0}
                 + {3'b000, d1_full[3:0]};
    video      = (chunk_type == TYPE_DC) || (chunk_type == TYPE_DB) || (num == video_stream);
    audio      = !video && ((chunk_type == TYPE_WB) || (num == audio_stream));
    hit        = digits_ok && (video || audio);
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = !empty && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && hit) begin
      chunk_offset  <= region_base + head_rec.pos;
      chunk_length  <= head_rec.size;
      is_audio      <= audio;
      key_frame     <= video;
      stream_number <= num;
    end
  end

endmodule

// ===== hdl/riff_movi_chunk_scanner.sv =====
// ----------------------------------------------------------------------------
// riff_movi_chunk_scanner
// Walks the chunks of an AVI movi region and reports audio and video chunks.
// ----------------------------------------------------------------------------
// The block takes one byte of the region per request and can accept a byte
// in every clock cycle. A front end follows the chunk structure: at every
// chunk boundary it collects the 8-byte header (tag, then size, both
// little-endian) if at least 8 bytes of the region remain, skips the 4-byte
// type after a LIST header and skips other payloads padded to even length
// (the size plus one wraps at 32 bits, so a size of all ones skips nothing).
// A byte with restart set begins a new scan at region offset zero; once the
// region is exhausted further bytes are ignored until the next restart.
// Every non-LIST header goes into a four-entry queue; unless stalled, a back
// end takes one header per cycle, decodes its two-digit stream number and
// chunk type, and presents a descriptor of a reported chunk through
// an output register. A chunk is reported as video when its type is dc or db
// or its number equals video_stream, else as audio when its type is wb or
// its number equals audio_stream. Input stall rises only when the queue is
// full, which needs the result side stalled for several headers in a row.
// Configuration registers must be written while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module riff_movi_chunk_scanner
  import rmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Byte requests.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  // Chunk descriptor requests.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] chunk_offset,
  output logic [31:0] chunk_length,
  output logic        is_audio,
  output logic        key_frame,
  output logic [6:0]  stream_number
);

  logic [31:0] region_base;
  logic [31:0] region_length;
  logic [6:0]  video_stream;
  logic [6:0]  audio_stream;

  logic        byte_fire;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  hdr_rec_t    push_rec;
  hdr_rec_t    head_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base   <= '0;
      region_length <= '0;
      video_stream  <= '0;
      audio_stream  <= AUDIO_STREAM_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_REGION_BASE:   region_base   <= cfg_data;
        REG_REGION_LENGTH: region_length <= cfg_data;
        REG_VIDEO_STREAM:  video_stream  <= cfg_data[6:0];
        REG_AUDIO_STREAM:  audio_stream  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // The front end only waits when there is no room for another header.
  assign in_stall  = full;
  assign byte_fire = in_valid && !in_stall;

  rmcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_fire     (byte_fire),
    .data_byte     (data_byte),
    .restart       (restart),
    .region_length (region_length),
    .push          (push),
    .push_rec      (push_rec)
  );

  rmcs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (empty),
    .full     (full)
  );

  rmcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_rec      (head_rec),
    .empty         (empty),
    .pop           (pop),
    .region_base   (region_base),
    .video_stream  (video_stream),
    .audio_stream  (audio_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chunk_offset  (chunk_offset),
    .chunk_length  (chunk_length),
    .is_audio      (is_audio),
    .key_frame     (key_frame),
    .stream_number (stream_number)
  );

  // A descriptor is either a video key frame or an audio chunk, never both.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_audio != key_frame))
    else $error("descriptor is both or neither audio and video");

  // Stream numbers come from two decimal digits.
  a_stream_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stream_number <= 7'd99))
    else $error("stream number out of range");

endmodule
